>>> rtl/fbpa_pkg.sv
package fbpa_pkg;

  // Mark memory row geometry
  localparam int unsigned ROW_W     = 32;
  localparam int unsigned ROW_SHIFT = 5;

  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned STRIDE_W  = 33;
  localparam int unsigned FREE_W    = 11;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_INIT  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_RANGE  = 3'd1,
    ST_ALIGN  = 3'd2,
    ST_DOUBLE = 3'd3,
    ST_FULL   = 3'd4,
    ST_BADCFG = 3'd5,
    ST_NOINIT = 3'd6
  } status_e;

  localparam logic [1:0] CFG_POOL_BASE     = 2'd0;
  localparam logic [1:0] CFG_POOL_BYTES    = 2'd1;
  localparam logic [1:0] CFG_PAYLOAD_BYTES = 2'd2;

  typedef struct packed {
    logic                start;
    logic [ADDR_W-1:0]   dividend;
    logic [STRIDE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [ADDR_W-1:0] quotient;
    logic [ADDR_W-1:0] remainder;
  } div_rsp_t;

endpackage

>>> rtl/fbpa_div.sv
// Restoring divider, one quotient bit per cycle.
module fbpa_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fbpa_pkg::div_req_t req_i,
  output fbpa_pkg::div_rsp_t rsp_o
);

  localparam int unsigned CNT_W = $clog2(fbpa_pkg::ADDR_W);

  logic                          busy_q;
  logic                          done_q;
  logic [CNT_W-1:0]              cnt_q;
  logic [fbpa_pkg::ADDR_W-1:0]   rem_q, rem_d;
  logic [fbpa_pkg::ADDR_W-1:0]   quo_q, quo_d;
  logic [fbpa_pkg::STRIDE_W-1:0] dvs_q;

  logic [fbpa_pkg::STRIDE_W-1:0] trial;
  logic [fbpa_pkg::STRIDE_W-1:0] diff;

  always_comb begin
    trial = {rem_q, quo_q[fbpa_pkg::ADDR_W-1]};
    diff  = trial - dvs_q;
    if (trial >= dvs_q) begin
      rem_d = diff[fbpa_pkg::ADDR_W-1:0];
      quo_d = {quo_q[fbpa_pkg::ADDR_W-2:0], 1'b1};
    end else begin
      rem_d = trial[fbpa_pkg::ADDR_W-1:0];
      quo_d = {quo_q[fbpa_pkg::ADDR_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !req_i.start && (cnt_q == CNT_W'(fbpa_pkg::ADDR_W - 1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(fbpa_pkg::ADDR_W - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

>>> rtl/fixed_block_pool_allocator.sv
// Fixed-size block pool allocator.
// Commands arrive on the s_axis channel (tuser = command, tdata = user address),
// one result per command leaves on m_axis (status, block address, free count).
// Pool geometry comes from three registers on the cfg write port; write them
// only while no command is in flight, then issue an init command.
// Command flow, from the accepting edge to the result on m_axis (receiver ready):
//   init  32 steps of the shared restoring divider, then the response state
//   free  same divider (offset / stride) plus a mark read-modify-write;
//         misaligned or out-of-range offsets answer once the divider is done
//   alloc first-fit scan that reads and then evaluates one 32-bit row of the mark
//         memory at a time, then a multiply and an add form the block address
//   errors found on accept go straight to the response state.
// One command at a time: s_axis_tready is high only while the sequencer idles.
// The result sits in an output register, so a new command is taken while the
// previous result still waits; a command that finishes while that register is
// still full holds in the response state until m_axis_tready frees it.
// Reset clears config, counters and pool_ready; block marks read as free through
// per-row valid bits cleared at reset and at every successful init (no sweep).
module fixed_block_pool_allocator #(
  parameter int unsigned MAX_BLOCKS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // command channel
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] user_address
  input  logic [1:0]  s_axis_tuser,   // [1:0] command
  // result channel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // [2:0] status, [34:3] block_address,
                                      // [45:35] free_blocks, [47:46] zero
);

  localparam int unsigned ROWS  = (MAX_BLOCKS + fbpa_pkg::ROW_W - 1) / fbpa_pkg::ROW_W;
  localparam int unsigned RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned GW    = RW + fbpa_pkg::ROW_SHIFT;
  localparam int unsigned CW    = $clog2(MAX_BLOCKS + 1);
  localparam logic [31:0] MaxQ  = 32'(MAX_BLOCKS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT_WAIT,
    S_FREE_WAIT,
    S_FREE_RD,
    S_FREE_CHK,
    S_SCAN_RD,
    S_SCAN_EV,
    S_ALLOC_MUL,
    S_ALLOC_ADD,
    S_RESP
  } state_e;

  // config registers
  logic [31:0] pool_base_q, pool_bytes_q, payload_bytes_q;

  // pool state
  logic [CW-1:0]                  block_total_q, free_total_q;
  logic [fbpa_pkg::STRIDE_W-1:0]  stride_q;
  logic                           pool_ready_q;
  logic [ROWS-1:0]                row_vld_q;

  // sequencer
  state_e                  state_q;
  logic [RW-1:0]           row_q;
  logic [GW-1:0]           idx_q;
  logic [31:0]             prod_q;
  fbpa_pkg::status_e       res_status_q;
  logic [31:0]             res_addr_q;
  logic                    m_valid_q;
  logic [47:0]             m_data_q;

  // mark memory, one row of 32 block marks per word
  logic [fbpa_pkg::ROW_W-1:0] mark_mem [ROWS];
  logic [fbpa_pkg::ROW_W-1:0] mark_rdata_q;
  logic                       mark_we;
  logic [fbpa_pkg::ROW_W-1:0] mark_wdata;

  fbpa_pkg::div_req_t div_req;
  fbpa_pkg::div_rsp_t div_rsp;

  // accept-time decode
  logic                       s_fire;
  fbpa_pkg::cmd_e             cmd_in;
  logic                       cfg_bad;
  logic [31:0]                hdr_addr, free_off;
  logic                       free_range_bad;

  // row evaluation
  logic [fbpa_pkg::ROW_W-1:0] eff_row, masked_row;
  logic                       scan_hit;
  logic [fbpa_pkg::ROW_SHIFT-1:0] scan_pos;
  logic [RW-1:0]              last_row;
  logic [fbpa_pkg::ROW_SHIFT-1:0] free_bit;

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign cmd_in        = fbpa_pkg::cmd_e'(s_axis_tuser);

  always_comb begin
    cfg_bad = (pool_base_q == '0) || (payload_bytes_q == '0) ||
              (pool_bytes_q < payload_bytes_q);
    hdr_addr = s_axis_tdata - 32'd1;
    free_off = hdr_addr - pool_base_q;
    free_range_bad = (s_axis_tdata == '0) || (hdr_addr < pool_base_q) ||
                     (free_off > pool_bytes_q);
  end

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = free_off;
    div_req.divisor  = stride_q;
    if (s_fire) begin
      if (cmd_in == fbpa_pkg::CMD_INIT) begin
        div_req.start    = !cfg_bad;
        div_req.dividend = pool_bytes_q;
        div_req.divisor  = {1'b0, payload_bytes_q} + 33'd1;
      end else if (cmd_in == fbpa_pkg::CMD_FREE) begin
        div_req.start    = pool_ready_q && !free_range_bad;
      end
    end
  end

  fbpa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Marks of blocks at or beyond block_total read as used, so the scan skips them.
  always_comb begin
    eff_row  = row_vld_q[row_q] ? mark_rdata_q : '0;
    scan_hit = 1'b0;
    scan_pos = '0;
    for (int j = 0; j < fbpa_pkg::ROW_W; j++) begin
      masked_row[j] = eff_row[j] ||
                      (32'({row_q, fbpa_pkg::ROW_SHIFT'(j)}) >= 32'(block_total_q));
    end
    for (int j = fbpa_pkg::ROW_W - 1; j >= 0; j--) begin
      if (!masked_row[j]) begin
        scan_hit = 1'b1;
        scan_pos = fbpa_pkg::ROW_SHIFT'(j);
      end
    end
    last_row = RW'((32'(block_total_q) - 32'd1) >> fbpa_pkg::ROW_SHIFT);
    free_bit = idx_q[fbpa_pkg::ROW_SHIFT-1:0];
  end

  always_comb begin
    mark_we    = 1'b0;
    mark_wdata = eff_row;
    if (state_q == S_SCAN_EV && scan_hit) begin
      mark_we             = 1'b1;
      mark_wdata[scan_pos] = 1'b1;
    end else if (state_q == S_FREE_CHK && eff_row[free_bit]) begin
      mark_we             = 1'b1;
      mark_wdata[free_bit] = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mark_we) begin
      mark_mem[row_q] <= mark_wdata;
    end
    mark_rdata_q <= mark_mem[row_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q     <= '0;
      pool_bytes_q    <= '0;
      payload_bytes_q <= '0;
      block_total_q   <= '0;
      free_total_q    <= '0;
      stride_q        <= '0;
      pool_ready_q    <= 1'b0;
      row_vld_q       <= '0;
      state_q         <= S_IDLE;
      row_q           <= '0;
      idx_q           <= '0;
      prod_q          <= '0;
      res_status_q    <= fbpa_pkg::ST_OK;
      res_addr_q      <= '0;
      m_valid_q       <= 1'b0;
      m_data_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          fbpa_pkg::CFG_POOL_BASE:     pool_base_q     <= cfg_data_i;
          fbpa_pkg::CFG_POOL_BYTES:    pool_bytes_q    <= cfg_data_i;
          fbpa_pkg::CFG_PAYLOAD_BYTES: payload_bytes_q <= cfg_data_i;
          default: ;
        endcase
      end

      // the response state reloads the output register itself
      if (m_valid_q && m_axis_tready && (state_q != S_RESP)) begin
        m_valid_q <= 1'b0;
      end

      if (mark_we) begin
        row_vld_q[row_q] <= 1'b1;
      end

      case (state_q)
        S_IDLE: begin
          if (s_fire) begin
            res_addr_q <= '0;
            case (cmd_in)
              fbpa_pkg::CMD_INIT: begin
                if (cfg_bad) begin
                  res_status_q <= fbpa_pkg::ST_BADCFG;
                  state_q      <= S_RESP;
                end else begin
                  state_q <= S_INIT_WAIT;
                end
              end
              fbpa_pkg::CMD_FREE: begin
                if (!pool_ready_q) begin
                  res_status_q <= fbpa_pkg::ST_NOINIT;
                  state_q      <= S_RESP;
                end else if (free_range_bad) begin
                  res_status_q <= fbpa_pkg::ST_RANGE;
                  state_q      <= S_RESP;
                end else begin
                  state_q <= S_FREE_WAIT;
                end
              end
              fbpa_pkg::CMD_ALLOC: begin
                if (!pool_ready_q) begin
                  res_status_q <= fbpa_pkg::ST_NOINIT;
                  state_q      <= S_RESP;
                end else if (free_total_q == '0) begin
                  res_status_q <= fbpa_pkg::ST_FULL;
                  state_q      <= S_RESP;
                end else begin
                  row_q   <= '0;
                  state_q <= S_SCAN_RD;
                end
              end
              default: begin
                res_status_q <= fbpa_pkg::ST_OK;
                state_q      <= S_RESP;
              end
            endcase
          end
        end

        S_INIT_WAIT: begin
          if (div_rsp.done) begin
            state_q <= S_RESP;
            if (div_rsp.quotient == '0) begin
              res_status_q <= fbpa_pkg::ST_BADCFG;
            end else begin
              res_status_q <= fbpa_pkg::ST_OK;
              if (div_rsp.quotient > MaxQ) begin
                block_total_q <= CW'(MaxQ);
                free_total_q  <= CW'(MaxQ);
              end else begin
                block_total_q <= CW'(div_rsp.quotient);
                free_total_q  <= CW'(div_rsp.quotient);
              end
              stride_q     <= {1'b0, payload_bytes_q} + 33'd1;
              pool_ready_q <= 1'b1;
              row_vld_q    <= '0;
            end
          end
        end

        S_FREE_WAIT: begin
          if (div_rsp.done) begin
            if (div_rsp.remainder != '0) begin
              res_status_q <= fbpa_pkg::ST_ALIGN;
              state_q      <= S_RESP;
            end else if (div_rsp.quotient >= 32'(block_total_q)) begin
              res_status_q <= fbpa_pkg::ST_RANGE;
              state_q      <= S_RESP;
            end else begin
              idx_q   <= GW'(div_rsp.quotient);
              row_q   <= RW'(div_rsp.quotient >> fbpa_pkg::ROW_SHIFT);
              state_q <= S_FREE_RD;
            end
          end
        end

        S_FREE_RD: state_q <= S_FREE_CHK;

        S_FREE_CHK: begin
          state_q <= S_RESP;
          if (eff_row[free_bit]) begin
            res_status_q <= fbpa_pkg::ST_OK;
            free_total_q <= free_total_q + 1'b1;
          end else begin
            res_status_q <= fbpa_pkg::ST_DOUBLE;
          end
        end

        S_SCAN_RD: state_q <= S_SCAN_EV;

        S_SCAN_EV: begin
          if (scan_hit) begin
            idx_q <= {row_q, scan_pos};
            if (free_total_q != '0) begin
              free_total_q <= free_total_q - 1'b1;
            end
            state_q <= S_ALLOC_MUL;
          end else if (row_q == last_row) begin
            res_status_q <= fbpa_pkg::ST_FULL;
            state_q      <= S_RESP;
          end else begin
            row_q   <= row_q + 1'b1;
            state_q <= S_SCAN_RD;
          end
        end

        S_ALLOC_MUL: begin
          prod_q  <= 32'(32'(idx_q) * stride_q[31:0]);
          state_q <= S_ALLOC_ADD;
        end

        S_ALLOC_ADD: begin
          res_addr_q   <= pool_base_q + prod_q + 32'd1;
          res_status_q <= fbpa_pkg::ST_OK;
          state_q      <= S_RESP;
        end

        S_RESP: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {2'b00, fbpa_pkg::FREE_W'(free_total_q), res_addr_q, res_status_q};
            state_q   <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

`ifndef SYNTH
  a_free_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_total_q <= block_total_q)
    else $error("free count exceeds block count");

  a_ready_has_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pool_ready_q |-> (block_total_q != '0) && (stride_q != '0))
    else $error("pool ready without blocks or stride");

  a_div_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_INIT_WAIT) || (state_q == S_FREE_WAIT))
    else $error("divider finished outside a wait state");

  a_init_all_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(state_q) == S_INIT_WAIT) && (res_status_q == fbpa_pkg::ST_OK) &&
    (state_q == S_RESP) |-> (free_total_q == block_total_q) && (row_vld_q == '0))
    else $error("init left blocks marked used");
`endif

endmodule
